// ----- hdl/batched_betweenness_centrality_assert.svh -----
// Assertion macros shared by the betweenness centrality block.
`ifndef BATCHED_BETWEENNESS_CENTRALITY_ASSERT_SVH
`define BATCHED_BETWEENNESS_CENTRALITY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bbc_pkg.sv -----
// Package: types, constants and control structs of the betweenness centrality block.
package bbc_pkg;

	// Parameter defaults
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_SOURCES_DEF  = 16;
	localparam int PATH_BITS_DEF    = 32;
	localparam int FRAC_BITS_DEF    = 16;

	// Fixed field widths
	localparam int VTX_W       = 6;
	localparam int SLOT_W      = 4;
	localparam int LVL_W       = 7;
	localparam int DEP_W       = 48;
	localparam int MUL_HALF    = DEP_W / 2;
	localparam int NV_W        = 7;
	localparam int NS_W        = 5;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;

	// First level that still has predecessors to back-propagate into
	localparam logic [LVL_W-1:0] LVL_BACK_MIN = LVL_W'(3);

	typedef enum logic [1:0] {
		OP_EDGE = 2'd0,
		OP_SRC  = 2'd1,
		OP_RUN  = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		CFG_NUM_VERTICES = 1'b0,
		CFG_NUM_SOURCES  = 1'b1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_SEED,
		S_BK_RD,
		S_BK_CHK,
		S_BJ_RD,
		S_BJ_UPD,
		S_LVL_END,
		S_QJ_RD,
		S_QJ_CHK,
		S_QJ_DIV,
		S_DK_RD,
		S_DK_CHK,
		S_DJ_RD,
		S_DJ_ADD,
		S_MUL_LO,
		S_MUL_HI,
		S_MUL_SUM,
		S_DEP_WR,
		S_ACC_RD,
		S_ACC_WR,
		S_EM_RD,
		S_EM_LOAD,
		S_EM_WAIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic adj_wr;
		logic src_wr;
		logic clr_wr;
		logic seed_wr;
		logic bfs_wr;
		logic row_load;
		logic div_start;
		logic q_wr;
		logic acc_clr;
		logic acc_add;
		logic mul_lo;
		logic mul_hi;
		logic mul_sum;
		logic dep_wr;
		logic cent_wr;
		logic cent_first;
		logic out_load;
		logic out_last;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [LVL_W-1:0] lvl;
		logic             row_hit;
		logic             div_done;
		logic [VTX_W-1:0] src_vtx;
	} dp_status_t;

endpackage

// ----- hdl/bbc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bbc_div import bbc_pkg::*; #(
	parameter int NUM_W = DEP_W,
	parameter int DEN_W = PATH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ----- hdl/bbc_dpath.sv -----
// Datapath: graph stores, per-source search memories, accumulators and output register.
module bbc_dpath import bbc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_SOURCES  = MAX_SOURCES_DEF,
	parameter int PATH_BITS    = PATH_BITS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int SW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [VW-1:0]     rd_addr,
	input  logic [VW-1:0]     wr_addr,
	input  logic [LVL_W-1:0]  level,
	input  logic [SW-1:0]     src_idx,
	input  logic [VTX_W-1:0]  row_vertex,
	input  logic [VTX_W-1:0]  col_vertex,
	input  logic              edge_present,
	input  logic [SLOT_W-1:0] source_slot,
	output dp_status_t        status,
	output logic [VTX_W-1:0]  out_vertex,
	output logic [DEP_W-1:0]  out_centrality,
	output logic              out_last
);

	localparam int ACC_W = DEP_W + VW;
	localparam int PW    = DEP_W + PATH_BITS;
	localparam logic [DEP_W-1:0] ONE_FX = {{(DEP_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [DEP_W-1:0] DEP_MAX = '1;

	// Stores
	logic [MAX_VERTICES-1:0] adj_mem  [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] adj_vld_q;
	logic [VTX_W-1:0]        src_mem  [MAX_SOURCES];
	logic [LVL_W-1:0]        lvl_mem  [MAX_VERTICES];
	logic [PATH_BITS-1:0]    sig_mem  [MAX_VERTICES];
	logic [DEP_W-1:0]        dep_mem  [MAX_VERTICES];
	logic [DEP_W-1:0]        q_mem    [MAX_VERTICES];
	logic [DEP_W-1:0]        cent_mem [MAX_VERTICES];

	// Registered read data
	logic [MAX_VERTICES-1:0] adj_rd_q;
	logic                    adj_vld_rd_q;
	logic [LVL_W-1:0]        lvl_rd_q;
	logic [PATH_BITS-1:0]    sig_rd_q;
	logic [DEP_W-1:0]        dep_rd_q;
	logic [DEP_W-1:0]        q_rd_q;
	logic [DEP_W-1:0]        cent_rd_q;

	// Working registers
	logic [MAX_VERTICES-1:0]     row_q;
	logic [PATH_BITS-1:0]        sigk_q;
	logic [DEP_W-1:0]            depk_q;
	logic [ACC_W-1:0]            acc_q;
	logic [MUL_HALF+PATH_BITS-1:0] p_lo_q;
	logic [MUL_HALF+PATH_BITS-1:0] p_hi_q;
	logic [DEP_W-1:0]            prod_q;
	logic [VTX_W-1:0]            out_vtx_q;
	logic [DEP_W-1:0]            out_cent_q;
	logic                        out_last_q;

	logic                 edge_ok;
	logic                 slot_ok;
	logic [VW-1:0]        row_idx;
	logic [VW-1:0]        col_idx;
	logic [LVL_W-1:0]     lvl_wd;
	logic [PATH_BITS-1:0] sig_wd;
	logic [DEP_W-1:0]     dep_wd;
	logic [DEP_W-1:0]     cent_wd;
	logic [PATH_BITS:0]   sig_sum;
	logic [DEP_W:0]       dep_sum;
	logic [DEP_W-1:0]     dep_less;
	logic [DEP_W:0]       cent_sum;
	logic [PW-1:0]        prod_full;
	logic [DEP_W-1:0]     quo;
	logic                 div_done;

	// Write address checks
	always_comb begin
		edge_ok = (32'(row_vertex) < MAX_VERTICES) && (32'(col_vertex) < MAX_VERTICES);
		slot_ok = 32'(source_slot) < MAX_SOURCES;
		row_idx = VW'(row_vertex);
		col_idx = VW'(col_vertex);
	end

	// Adjacency rows: a row never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q <= '0;
		end else if (cmd.adj_wr && edge_ok) begin
			adj_vld_q[row_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adj_wr && edge_ok) begin
			if (adj_vld_q[row_idx]) begin
				adj_mem[row_idx][col_idx] <= edge_present;
			end else begin
				adj_mem[row_idx] <= MAX_VERTICES'(edge_present) << col_idx;
			end
		end
		adj_rd_q     <= adj_mem[rd_addr];
		adj_vld_rd_q <= adj_vld_q[rd_addr];
	end

	// Source list
	always_ff @(posedge clk) begin
		if (cmd.src_wr && slot_ok) begin
			src_mem[SW'(source_slot)] <= row_vertex;
		end
	end

	// Write data for the search memories
	always_comb begin
		sig_sum  = {1'b0, sig_rd_q} + {1'b0, sigk_q};
		dep_sum  = {1'b0, depk_q} + {1'b0, prod_q};
		dep_less = dep_rd_q - ONE_FX;
		cent_sum = {1'b0, cent_rd_q} + {1'b0, dep_less};
		priority if (cmd.clr_wr) begin
			lvl_wd = '0;
			sig_wd = '0;
			dep_wd = ONE_FX;
		end else if (cmd.seed_wr) begin
			lvl_wd = LVL_W'(1);
			sig_wd = PATH_BITS'(1);
			dep_wd = ONE_FX;
		end else begin
			lvl_wd = level + LVL_W'(1);
			sig_wd = sig_sum[PATH_BITS] ? '1 : sig_sum[PATH_BITS-1:0];
			dep_wd = dep_sum[DEP_W] ? DEP_MAX : dep_sum[DEP_W-1:0];
		end
		if (cmd.cent_first) begin
			cent_wd = dep_less;
		end else begin
			cent_wd = cent_sum[DEP_W] ? DEP_MAX : cent_sum[DEP_W-1:0];
		end
	end

	// Level, path count, dependency, quotient and centrality memories
	always_ff @(posedge clk) begin
		if (cmd.clr_wr || cmd.seed_wr || cmd.bfs_wr) begin
			lvl_mem[wr_addr] <= lvl_wd;
			sig_mem[wr_addr] <= sig_wd;
		end
		if (cmd.clr_wr || cmd.dep_wr) begin
			dep_mem[wr_addr] <= dep_wd;
		end
		if (cmd.q_wr) begin
			q_mem[wr_addr] <= quo;
		end
		if (cmd.cent_wr) begin
			cent_mem[wr_addr] <= cent_wd;
		end
		lvl_rd_q  <= lvl_mem[rd_addr];
		sig_rd_q  <= sig_mem[rd_addr];
		dep_rd_q  <= dep_mem[rd_addr];
		q_rd_q    <= q_mem[rd_addr];
		cent_rd_q <= cent_mem[rd_addr];
	end

	// Quotient dependency / path count
	bbc_div #(
		.NUM_W(DEP_W),
		.DEN_W(PATH_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (dep_rd_q),
		.den   (sig_rd_q),
		.quo   (quo),
		.done  (div_done)
	);

	// Product of the quotient sum and the path count, in two halves
	always_comb begin
		prod_full = {p_hi_q, {MUL_HALF{1'b0}}} + PW'(p_lo_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.row_load) begin
			row_q  <= adj_vld_rd_q ? adj_rd_q : '0;
			sigk_q <= sig_rd_q;
			depk_q <= dep_rd_q;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACC_W'(q_rd_q);
		end
		if (cmd.mul_lo) begin
			p_lo_q <= acc_q[MUL_HALF-1:0] * sigk_q;
		end
		if (cmd.mul_hi) begin
			p_hi_q <= acc_q[DEP_W-1:MUL_HALF] * sigk_q;
		end
		if (cmd.mul_sum) begin
			prod_q <= (acc_q[ACC_W-1:DEP_W] != '0 || prod_full[PW-1:DEP_W] != '0) ?
				DEP_MAX : prod_full[DEP_W-1:0];
		end
		if (cmd.out_load) begin
			out_vtx_q  <= VTX_W'(wr_addr);
			out_cent_q <= cent_rd_q;
			out_last_q <= cmd.out_last;
		end
	end

	// Status
	always_comb begin
		status.lvl      = lvl_rd_q;
		status.row_hit  = row_q[rd_addr];
		status.div_done = div_done;
		status.src_vtx  = src_mem[src_idx];
	end

	assign out_vertex     = out_vtx_q;
	assign out_centrality = out_cent_q;
	assign out_last       = out_last_q;

endmodule

// ----- hdl/bbc_ctrl.sv -----
// Controller: configuration registers, loop counters and the sequencing state machine.
module bbc_ctrl import bbc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_SOURCES  = MAX_SOURCES_DEF,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int SW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_op,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_index,
	input  logic [NV_W-1:0]  cfg_data,
	input  dp_status_t       status,
	output dp_cmd_t          cmd,
	output logic [VW-1:0]    rd_addr,
	output logic [VW-1:0]    wr_addr,
	output logic [LVL_W-1:0] level,
	output logic [SW-1:0]    src_idx
);

	state_t           state_q, state_d;
	logic [NV_W-1:0]  nv_q;
	logic [NS_W-1:0]  ns_q;
	logic [VW-1:0]    n_m1_q, n_m1_d;
	logic [SW-1:0]    ns_m1_q, ns_m1_d;
	logic [VW-1:0]    idx_q;
	logic [VW-1:0]    k_q;
	logic [SW-1:0]    r_q;
	logic [LVL_W-1:0] lvl_q;
	logic             grew_q;

	logic             in_acc;
	logic             run_acc;
	logic             idx_last;
	logic             k_last;
	logic             r_last;
	logic             lvl_eq;
	logic             lvl_eq_up;
	logic             lvl_open;
	logic             src_oor;
	logic             lvl_at_n;
	logic [LVL_W-1:0] bt_lvl;
	logic             bt_go;
	logic             lvl_floor;

	// Handshake and loop conditions
	always_comb begin
		in_acc    = in_valid && in_ready;
		run_acc   = in_acc && (in_op == OP_RUN);
		idx_last  = idx_q == n_m1_q;
		k_last    = k_q == n_m1_q;
		r_last    = r_q == ns_m1_q;
		lvl_eq    = status.lvl == lvl_q;
		lvl_eq_up = status.lvl == (lvl_q - LVL_W'(1));
		lvl_open  = (status.lvl == '0) || (status.lvl == (lvl_q + LVL_W'(1)));
		src_oor   = NV_W'(status.src_vtx) > NV_W'(n_m1_q);
		lvl_at_n  = lvl_q == (LVL_W'(n_m1_q) + LVL_W'(1));
		bt_lvl    = grew_q ? (lvl_q + LVL_W'(1)) : lvl_q;
		bt_go     = bt_lvl >= LVL_BACK_MIN;
		lvl_floor = lvl_q == LVL_BACK_MIN;
	end

	// Effective vertex and source counts
	always_comb begin
		priority if (nv_q == '0) begin
			n_m1_d = '0;
		end else if (32'(nv_q) > MAX_VERTICES) begin
			n_m1_d = VW'(MAX_VERTICES - 1);
		end else begin
			n_m1_d = VW'(nv_q - NV_W'(1));
		end
		priority if (ns_q == '0) begin
			ns_m1_d = '0;
		end else if (32'(ns_q) > MAX_SOURCES) begin
			ns_m1_d = SW'(MAX_SOURCES - 1);
		end else begin
			ns_m1_d = SW'(ns_q - NS_W'(1));
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (run_acc) state_d = S_CLR;
			S_CLR:     if (idx_q == VW'(MAX_VERTICES - 1)) state_d = S_SEED;
			S_SEED:    state_d = src_oor ? S_ACC_RD : S_BK_RD;
			S_BK_RD:   state_d = S_BK_CHK;
			S_BK_CHK: begin
				if (lvl_eq) state_d = S_BJ_RD;
				else state_d = k_last ? S_LVL_END : S_BK_RD;
			end
			S_BJ_RD: begin
				if (status.row_hit) state_d = S_BJ_UPD;
				else if (idx_last) state_d = k_last ? S_LVL_END : S_BK_RD;
			end
			S_BJ_UPD: begin
				if (idx_last) state_d = k_last ? S_LVL_END : S_BK_RD;
				else state_d = S_BJ_RD;
			end
			S_LVL_END: begin
				if (grew_q && !lvl_at_n) state_d = S_BK_RD;
				else state_d = bt_go ? S_QJ_RD : S_ACC_RD;
			end
			S_QJ_RD:   state_d = S_QJ_CHK;
			S_QJ_CHK: begin
				if (lvl_eq) state_d = S_QJ_DIV;
				else state_d = idx_last ? S_DK_RD : S_QJ_RD;
			end
			S_QJ_DIV:  if (status.div_done) state_d = idx_last ? S_DK_RD : S_QJ_RD;
			S_DK_RD:   state_d = S_DK_CHK;
			S_DK_CHK: begin
				if (lvl_eq_up) state_d = S_DJ_RD;
				else if (k_last) state_d = lvl_floor ? S_ACC_RD : S_QJ_RD;
				else state_d = S_DK_RD;
			end
			S_DJ_RD: begin
				if (status.row_hit) state_d = S_DJ_ADD;
				else if (idx_last) state_d = S_MUL_LO;
			end
			S_DJ_ADD:  state_d = idx_last ? S_MUL_LO : S_DJ_RD;
			S_MUL_LO:  state_d = S_MUL_HI;
			S_MUL_HI:  state_d = S_MUL_SUM;
			S_MUL_SUM: state_d = S_DEP_WR;
			S_DEP_WR: begin
				if (k_last) state_d = lvl_floor ? S_ACC_RD : S_QJ_RD;
				else state_d = S_DK_RD;
			end
			S_ACC_RD:  state_d = S_ACC_WR;
			S_ACC_WR: begin
				if (idx_last) state_d = r_last ? S_EM_RD : S_CLR;
				else state_d = S_ACC_RD;
			end
			S_EM_RD:   state_d = S_EM_LOAD;
			S_EM_LOAD: state_d = S_EM_WAIT;
			S_EM_WAIT: if (out_ready) state_d = idx_last ? S_IDLE : S_EM_RD;
			default:   state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		rd_addr   = idx_q;
		wr_addr   = idx_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.adj_wr = in_acc && (in_op == OP_EDGE);
				cmd.src_wr = in_acc && (in_op == OP_SRC);
			end
			S_CLR:     cmd.clr_wr = 1'b1;
			S_SEED: begin
				cmd.seed_wr = !src_oor;
				wr_addr = VW'(status.src_vtx);
			end
			S_BK_RD:   rd_addr = k_q;
			S_BK_CHK:  cmd.row_load = lvl_eq;
			S_BJ_UPD:  cmd.bfs_wr = lvl_open;
			S_QJ_CHK:  cmd.div_start = lvl_eq;
			S_QJ_DIV:  cmd.q_wr = status.div_done;
			S_DK_RD:   rd_addr = k_q;
			S_DK_CHK: begin
				cmd.row_load = lvl_eq_up;
				cmd.acc_clr  = lvl_eq_up;
			end
			S_DJ_ADD:  cmd.acc_add = lvl_eq;
			S_MUL_LO:  cmd.mul_lo = 1'b1;
			S_MUL_HI:  cmd.mul_hi = 1'b1;
			S_MUL_SUM: cmd.mul_sum = 1'b1;
			S_DEP_WR: begin
				cmd.dep_wr = 1'b1;
				wr_addr = k_q;
			end
			S_ACC_WR: begin
				cmd.cent_wr    = 1'b1;
				cmd.cent_first = r_q == '0;
			end
			S_EM_LOAD: begin
				cmd.out_load = 1'b1;
				cmd.out_last = idx_last;
			end
			S_EM_WAIT: out_valid = 1'b1;
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign level     = lvl_q;
	assign src_idx   = r_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= NV_W'(64);
			ns_q <= NS_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_NUM_VERTICES: nv_q <= cfg_data;
				CFG_NUM_SOURCES:  ns_q <= cfg_data[NS_W-1:0];
				default:          nv_q <= nv_q;
			endcase
		end
	end

	// State and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_m1_q  <= '0;
			ns_m1_q <= '0;
			idx_q   <= '0;
			k_q     <= '0;
			r_q     <= '0;
			lvl_q   <= '0;
			grew_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (run_acc) begin
						n_m1_q  <= n_m1_d;
						ns_m1_q <= ns_m1_d;
						r_q     <= '0;
						idx_q   <= '0;
					end
				end
				S_CLR: begin
					idx_q <= (idx_q == VW'(MAX_VERTICES - 1)) ? '0 : idx_q + VW'(1);
				end
				S_SEED: begin
					k_q    <= '0;
					idx_q  <= '0;
					lvl_q  <= LVL_W'(1);
					grew_q <= 1'b0;
				end
				S_BK_CHK: begin
					if (lvl_eq) idx_q <= '0;
					else if (!k_last) k_q <= k_q + VW'(1);
				end
				S_BJ_RD: begin
					if (!status.row_hit) begin
						if (!idx_last) idx_q <= idx_q + VW'(1);
						else if (!k_last) k_q <= k_q + VW'(1);
					end
				end
				S_BJ_UPD: begin
					if (lvl_open) grew_q <= 1'b1;
					if (!idx_last) idx_q <= idx_q + VW'(1);
					else if (!k_last) k_q <= k_q + VW'(1);
				end
				S_LVL_END: begin
					if (grew_q && !lvl_at_n) begin
						lvl_q  <= lvl_q + LVL_W'(1);
						k_q    <= '0;
						grew_q <= 1'b0;
					end else begin
						lvl_q <= bt_lvl;
						idx_q <= '0;
					end
				end
				S_QJ_CHK: begin
					if (!lvl_eq) begin
						if (idx_last) k_q <= '0;
						else idx_q <= idx_q + VW'(1);
					end
				end
				S_QJ_DIV: begin
					if (status.div_done) begin
						if (idx_last) k_q <= '0;
						else idx_q <= idx_q + VW'(1);
					end
				end
				S_DK_CHK: begin
					if (lvl_eq_up) begin
						idx_q <= '0;
					end else if (k_last) begin
						idx_q <= '0;
						lvl_q <= lvl_q - LVL_W'(1);
					end else begin
						k_q <= k_q + VW'(1);
					end
				end
				S_DJ_RD: begin
					if (!status.row_hit && !idx_last) idx_q <= idx_q + VW'(1);
				end
				S_DJ_ADD: begin
					if (!idx_last) idx_q <= idx_q + VW'(1);
				end
				S_DEP_WR: begin
					if (k_last) begin
						idx_q <= '0;
						lvl_q <= lvl_q - LVL_W'(1);
					end else begin
						k_q <= k_q + VW'(1);
					end
				end
				S_ACC_WR: begin
					if (idx_last) begin
						idx_q <= '0;
						if (!r_last) r_q <= r_q + SW'(1);
					end else begin
						idx_q <= idx_q + VW'(1);
					end
				end
				S_EM_WAIT: begin
					if (out_ready && !idx_last) idx_q <= idx_q + VW'(1);
				end
				default: begin
					grew_q <= grew_q;
				end
			endcase
		end
	end

endmodule

// ----- hdl/batched_betweenness_centrality.sv -----
// Top level of the sampled-source betweenness centrality engine.
//
// Input channel s_*: one item per cycle while idle. s_tuser is the operation:
// edge write, source list write or run. Edge and source writes give no result.
// A run searches from each active source in turn and then emits one result per
// vertex 0..n-1 on m_*, m_tlast on the final vertex.
// Per source the block clears the search memories over all MAX_VERTICES
// entries. Each search level scans the vertices, and each vertex on the level
// then has its row scanned. Each backtrack level divides the dependency of
// each vertex on the level by its path count and, for each predecessor one
// level up, sums the quotients over its row and multiplies by its path count.
// Then the source is folded into the sums. Each memory has a single read port.
// Each result is loaded into the output register and held on m_*; while the
// receiver stalls the result holds and the block waits. s_tready is low from
// the run item until the last result is taken.
// Configuration writes (cfg_*) are always ready; they are meant for idle time.
// Reset clears the adjacency store (no edges), sets num_vertices to 64 and
// num_sources to 1, and returns to idle; the source list is undefined until
// written.
`include "batched_betweenness_centrality_assert.svh"
module batched_betweenness_centrality import bbc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_SOURCES  = MAX_SOURCES_DEF,
	parameter int PATH_BITS    = PATH_BITS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// row_vertex[5:0], col_vertex[11:6], edge_present[12], source_slot[16:13]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// vertex[5:0], centrality[53:6]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [0:0]             cfg_index,
	input  logic [NV_W-1:0]        cfg_data
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int SW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

	dp_cmd_t          cmd;
	dp_status_t       status;
	logic [VW-1:0]    rd_addr;
	logic [VW-1:0]    wr_addr;
	logic [LVL_W-1:0] level;
	logic [SW-1:0]    src_idx;
	logic [VTX_W-1:0] out_vertex;
	logic [DEP_W-1:0] out_centrality;

	bbc_ctrl #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_SOURCES (MAX_SOURCES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.status   (status),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.level    (level),
		.src_idx  (src_idx)
	);

	bbc_dpath #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_SOURCES (MAX_SOURCES),
		.PATH_BITS   (PATH_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.wr_addr       (wr_addr),
		.level         (level),
		.src_idx       (src_idx),
		.row_vertex    (s_tdata[5:0]),
		.col_vertex    (s_tdata[11:6]),
		.edge_present  (s_tdata[12]),
		.source_slot   (s_tdata[16:13]),
		.status        (status),
		.out_vertex    (out_vertex),
		.out_centrality(out_centrality),
		.out_last      (m_tlast)
	);

	assign m_tdata = {{(OUT_TDATA_W-VTX_W-DEP_W){1'b0}}, out_centrality, out_vertex};

	// Input is taken only when no result is pending
	`BBC_ASSERT_SAME(a_no_overlap, clk, arst_n, s_tready, !m_tvalid, "input ready while result pending")
	// A run item locks out further input
	`BBC_ASSERT_NEXT(a_run_busy, clk, arst_n, s_tvalid && s_tready && (s_tuser == OP_RUN), !s_tready, "input ready right after run")
	// After the final result is taken the block is idle again
	`BBC_ASSERT_NEXT(a_last_idle, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid, "not idle after last result")

endmodule
